### hdl/sst_pkg.sv
// Shared types, constants and saturation helpers for the sphere tracer.
package sst_pkg;

  localparam int MAX_STEPS_DEF = 15;
  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [30:0] SIZE_RESET = 31'd65536;

  typedef enum logic [1:0] {
    SHAPE_SPHERE,
    SHAPE_BOX,
    SHAPE_TORUS,
    SHAPE_CYLINDER
  } shape_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHAPE,
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_CENTER_Z,
    REG_SIZE_A,
    REG_SIZE_B,
    REG_SIZE_C
  } cfg_reg_t;

  localparam logic signed [35:0] S32_MAX = 36'sd2147483647;
  localparam logic signed [35:0] S32_MIN = -36'sd2147483648;
  localparam logic [35:0] MAG_LIMIT = 36'd2147483648;

  // Magnitude of a signed value, saturated at 2^31.
  function automatic logic [31:0] mag_sat(input logic signed [35:0] v);
    logic [35:0] m;
    m = v[35] ? 36'(-v) : 36'(v);
    if (m > MAG_LIMIT) begin
      return 32'h8000_0000;
    end
    return m[31:0];
  endfunction

  // Saturate a signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > S32_MAX) begin
      return 32'sh7fff_ffff;
    end
    if (v < S32_MIN) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

### hdl/sst_isqrt.sv
// Iterative floor square root of a 64-bit value, one result bit per cycle.
module sst_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);
  import sst_pkg::*;

  logic [63:0] x;
  logic [63:0] r;
  logic [63:0] bit_r;
  logic [4:0]  cnt;
  logic        run;
  logic [64:0] trial;

  assign trial = {1'b0, r} + {1'b0, bit_r};
  assign root = r[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        x <= radicand;
        r <= '0;
        bit_r <= 64'h4000_0000_0000_0000;
        cnt <= '0;
        run <= 1'b1;
      end else if (run) begin
        if ({1'b0, x} >= trial) begin
          x <= x - trial[63:0];
          r <= (r >> 1) + bit_r;
        end else begin
          r <= r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### hdl/sst_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module sst_div #(
  parameter int NW = 48
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  logic [NW-1:0] num,
  input  logic [31:0]   den,
  output logic          done,
  output logic [NW-1:0] quot
);
  import sst_pkg::*;

  localparam int CW = $clog2(NW + 1);
  localparam logic [CW-1:0] LAST = CW'(NW - 1);

  logic [31:0]   rem;
  logic [NW-1:0] q;
  logic [CW-1:0] cnt;
  logic          run;
  logic [32:0]   rem_sh;

  assign rem_sh = {rem, q[NW-1]};
  assign quot = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        rem <= '0;
        q <= num;
        cnt <= '0;
        run <= 1'b1;
      end else if (run) begin
        if (rem_sh >= {1'b0, den}) begin
          rem <= 32'(rem_sh - {1'b0, den});
          q <= {q[NW-2:0], 1'b1};
        end else begin
          rem <= rem_sh[31:0];
          q <= {q[NW-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### hdl/sdf_sphere_tracer_core.sv
// Top level: sequencer, shared multiplier and configuration of the sphere tracer.
// Each field evaluation runs through the square root unit (twice for the torus); a ray
// takes MAX_STEPS + 2 evaluations at most, plus three more and a length and three
// divisions on a hit (the divisions only when the length is nonzero).
// Throughput: one ray at a time; start is taken only while busy is low.
// Reset is synchronous and returns the sequencer to idle and the registers to defaults.
module sdf_sphere_tracer_core #(
  parameter int MAX_STEPS = sst_pkg::MAX_STEPS_DEF,
  parameter int FRAC_BITS = sst_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [sst_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sst_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [31:0]                origin_x,
  input  logic signed [31:0]                origin_y,
  input  logic signed [31:0]                origin_z,
  input  logic signed [17:0]                direction_x,
  input  logic signed [17:0]                direction_y,
  input  logic signed [17:0]                direction_z,
  input  logic [30:0]                       start_t,
  output logic                              done,
  output logic                              hit,
  output logic signed [31:0]                signed_distance,
  output logic signed [31:0]                hit_x,
  output logic signed [31:0]                hit_y,
  output logic signed [31:0]                hit_z,
  output logic signed [17:0]                normal_x,
  output logic signed [17:0]                normal_y,
  output logic signed [17:0]                normal_z
);
  import sst_pkg::*;

  localparam int ONE_FX = 1 << FRAC_BITS;
  localparam int HIT_EPS = (ONE_FX + 50) / 100;
  localparam int NRM_DELTA = (ONE_FX + 500) / 1000;
  localparam int STEP_W = $clog2(MAX_STEPS + 1);
  localparam int DIV_W = 32 + FRAC_BITS;
  localparam logic [31:0] EPS_V = 32'(HIT_EPS);
  localparam logic signed [35:0] DELTA_V = 36'(NRM_DELTA);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MAX_STEPS);
  localparam logic [63:0] SHIFT_LIMIT = 64'h2_0000_0000;
  localparam logic signed [34:0] G_MAX = 35'sd2147483648;
  localparam logic signed [34:0] G_MIN = -35'sd2147483648;

  typedef enum logic [3:0] {
    S_IDLE, S_PT, S_PT_DONE, S_PREP, S_SQ, S_SQ_GO, S_SQ_WAIT, S_POST,
    S_MARCH, S_DIV_GO, S_DIV_WAIT, S_OUT
  } state_t;

  typedef enum logic [2:0] {
    PH_START, PH_NUDGE, PH_MARCH, PH_NX, PH_NY, PH_NZ, PH_LEN
  } phase_t;

  shape_t shape_kind;
  logic signed [31:0] center_x, center_y, center_z;
  logic [30:0] size_a, size_b, size_c;

  state_t state;
  phase_t phase;
  logic done_r, hit_r, tpass;
  logic [1:0] idx;
  logic [STEP_W-1:0] step;
  logic [30:0] t;
  logic signed [31:0] sd;
  logic signed [31:0] ovec [3];
  logic signed [17:0] dvec [3];
  logic signed [31:0] pvec [3];
  logic signed [31:0] fvec [3];
  logic signed [35:0] u [3];
  logic signed [35:0] inner;
  logic signed [32:0] gvec [3];
  logic signed [17:0] nvec [3];
  logic [31:0] len;
  logic [63:0] acc;
  logic [63:0] prod;
  logic pneg;

  logic [31:0] mul_a, mul_b;
  logic signed [17:0] d_sel;
  logic [17:0] dabs;
  logic signed [35:0] u_sel;
  logic [63:0] shifted, sh_c;
  logic signed [35:0] o_sel, psum;
  logic signed [31:0] pnew;
  logic [1:0] pidx;
  logic signed [31:0] cvec [3];
  logic [29:0] hvec [3];
  logic signed [35:0] u_prep [3];
  logic signed [35:0] bx [3];
  logic signed [35:0] bmax, inner_prep;
  logic sq_go, sq_done;
  logic [31:0] sq_root;
  logic div_go, div_done;
  logic [DIV_W-1:0] div_num, div_quot;
  logic [31:0] g_mag;
  logic [17:0] q18;
  logic signed [35:0] r_val, qx;
  logic signed [31:0] fval;
  logic [31:0] fmag, sdmag;
  logic [31:0] t_eps;
  logic [32:0] t_step;
  logic signed [34:0] gdiff;
  logic signed [32:0] gcl;

  always_ff @(posedge clk) begin
    if (rst) begin
      shape_kind <= SHAPE_SPHERE;
      center_x <= '0;
      center_y <= '0;
      center_z <= '0;
      size_a <= SIZE_RESET;
      size_b <= SIZE_RESET;
      size_c <= SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SHAPE:    shape_kind <= shape_t'(cfg_data[1:0]);
        REG_CENTER_X: center_x <= cfg_data;
        REG_CENTER_Y: center_y <= cfg_data;
        REG_CENTER_Z: center_z <= cfg_data;
        REG_SIZE_A:   size_a <= cfg_data[30:0];
        REG_SIZE_B:   size_b <= cfg_data[30:0];
        REG_SIZE_C:   size_c <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  assign cvec[0] = center_x;
  assign cvec[1] = center_y;
  assign cvec[2] = center_z;
  assign hvec[0] = size_a[30:1];
  assign hvec[1] = size_b[30:1];
  assign hvec[2] = size_c[30:1];

  always_comb begin
    case (idx)
      2'd0: d_sel = dvec[0];
      2'd1: d_sel = dvec[1];
      2'd2: d_sel = dvec[2];
      default: d_sel = '0;
    endcase
    case (idx)
      2'd0: u_sel = u[0];
      2'd1: u_sel = u[1];
      2'd2: u_sel = u[2];
      default: u_sel = '0;
    endcase
  end

  assign dabs = d_sel[17] ? 18'(-d_sel) : 18'(d_sel);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == S_PT && idx != 2'd3) begin
      mul_a = {14'd0, dabs};
      mul_b = {1'b0, t};
    end else if (state == S_SQ && idx != 2'd3) begin
      mul_a = mag_sat(u_sel);
      mul_b = mag_sat(u_sel);
    end
  end

  // Point coordinate from the registered product of the previous cycle.
  assign pidx = idx - 2'd1;
  assign shifted = prod >> FRAC_BITS;
  assign sh_c = (shifted > SHIFT_LIMIT) ? SHIFT_LIMIT : shifted;
  assign o_sel = 36'(ovec[pidx]);
  assign psum = pneg ? (o_sel - $signed({2'b00, sh_c[33:0]}))
                     : (o_sel + $signed({2'b00, sh_c[33:0]}));
  assign pnew = sat32(psum);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      bx[k] = $signed({4'd0, mag_sat(36'(fvec[k]) - 36'(cvec[k]))})
              - $signed({6'd0, hvec[k]});
    end
    bmax = bx[0];
    if (bx[1] > bmax) begin
      bmax = bx[1];
    end
    if (bx[2] > bmax) begin
      bmax = bx[2];
    end
    inner_prep = bmax[35] ? bmax : '0;
    case (shape_kind)
      SHAPE_SPHERE: begin
        for (int k = 0; k < 3; k++) begin
          u_prep[k] = 36'(fvec[k]) - 36'(cvec[k]);
        end
      end
      SHAPE_BOX: begin
        for (int k = 0; k < 3; k++) begin
          u_prep[k] = bx[k][35] ? '0 : bx[k];
        end
      end
      default: begin
        u_prep[0] = 36'(fvec[0]);
        u_prep[1] = 36'(fvec[2]);
        u_prep[2] = '0;
      end
    endcase
  end

  assign qx = $signed({4'd0, sq_root}) - $signed({5'd0, size_a});

  always_comb begin
    case (shape_kind)
      SHAPE_BOX:   r_val = inner + $signed({4'd0, sq_root});
      SHAPE_TORUS: r_val = $signed({4'd0, sq_root}) - $signed({5'd0, size_b});
      default:     r_val = qx;
    endcase
  end

  assign fval = sat32(r_val);
  assign fmag = fval[31] ? 32'(-fval) : 32'(fval);
  assign sdmag = sd[31] ? 32'(-sd) : 32'(sd);
  assign t_eps = {1'b0, t} + EPS_V;
  assign t_step = {2'b00, t} + {1'b0, sdmag};
  assign gdiff = 35'(fval) - 35'(sd);
  assign gcl = (gdiff > G_MAX) ? 33'(G_MAX) : ((gdiff < G_MIN) ? 33'(G_MIN) : 33'(gdiff));

  assign sq_go = (state == S_SQ_GO);
  assign div_go = (state == S_DIV_GO);
  assign g_mag = mag_sat(36'(gvec[idx]));
  assign div_num = {g_mag, FRAC_BITS'(0)};
  assign q18 = div_quot[17:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      prod <= mul_a * mul_b;
      pneg <= d_sel[17];
      case (state)
        S_IDLE: begin
          if (start) begin
            ovec[0] <= origin_x;
            ovec[1] <= origin_y;
            ovec[2] <= origin_z;
            dvec[0] <= direction_x;
            dvec[1] <= direction_y;
            dvec[2] <= direction_z;
            t <= start_t;
            hit_r <= 1'b0;
            for (int k = 0; k < 3; k++) begin
              nvec[k] <= '0;
            end
            phase <= PH_START;
            idx <= '0;
            state <= S_PT;
          end
        end
        S_PT: begin
          if (idx != 2'd0) begin
            pvec[pidx] <= pnew;
          end
          if (idx == 2'd3) begin
            state <= S_PT_DONE;
          end else begin
            idx <= idx + 2'd1;
          end
        end
        S_PT_DONE: begin
          for (int k = 0; k < 3; k++) begin
            fvec[k] <= pvec[k];
          end
          state <= S_PREP;
        end
        S_PREP: begin
          for (int k = 0; k < 3; k++) begin
            u[k] <= u_prep[k];
          end
          inner <= inner_prep;
          tpass <= 1'b0;
          acc <= '0;
          idx <= '0;
          state <= S_SQ;
        end
        S_SQ: begin
          acc <= acc + prod;
          idx <= idx + 2'd1;
          if (idx == 2'd3) begin
            state <= S_SQ_GO;
          end
        end
        S_SQ_GO: begin
          state <= S_SQ_WAIT;
        end
        S_SQ_WAIT: begin
          if (sq_done) begin
            state <= S_POST;
          end
        end
        S_POST: begin
          if (phase == PH_LEN) begin
            len <= sq_root;
            idx <= '0;
            state <= (sq_root == '0) ? S_OUT : S_DIV_GO;
          end else if (shape_kind == SHAPE_TORUS && !tpass) begin
            u[0] <= qx;
            u[1] <= 36'(fvec[1]);
            u[2] <= '0;
            tpass <= 1'b1;
            acc <= '0;
            idx <= '0;
            state <= S_SQ;
          end else begin
            case (phase)
              PH_START: begin
                sd <= fval;
                if (fmag < EPS_V) begin
                  t <= t_eps[31] ? 31'h7fff_ffff : t_eps[30:0];
                  phase <= PH_NUDGE;
                  idx <= '0;
                  state <= S_PT;
                end else begin
                  phase <= PH_MARCH;
                  step <= '0;
                  state <= S_MARCH;
                end
              end
              PH_NUDGE: begin
                sd <= fval;
                phase <= PH_MARCH;
                step <= '0;
                state <= S_MARCH;
              end
              PH_MARCH: begin
                sd <= fval;
                if (fmag < EPS_V) begin
                  hit_r <= 1'b1;
                  fvec[0] <= sat32(36'(pvec[0]) + DELTA_V);
                  fvec[1] <= pvec[1];
                  fvec[2] <= pvec[2];
                  phase <= PH_NX;
                  state <= S_PREP;
                end else begin
                  state <= S_MARCH;
                end
              end
              PH_NX: begin
                gvec[0] <= gcl;
                fvec[0] <= pvec[0];
                fvec[1] <= sat32(36'(pvec[1]) + DELTA_V);
                phase <= PH_NY;
                state <= S_PREP;
              end
              PH_NY: begin
                gvec[1] <= gcl;
                fvec[1] <= pvec[1];
                fvec[2] <= sat32(36'(pvec[2]) + DELTA_V);
                phase <= PH_NZ;
                state <= S_PREP;
              end
              default: begin
                gvec[2] <= gcl;
                u[0] <= 36'(gvec[0]);
                u[1] <= 36'(gvec[1]);
                u[2] <= 36'(gcl);
                phase <= PH_LEN;
                acc <= '0;
                idx <= '0;
                state <= S_SQ;
              end
            endcase
          end
        end
        S_MARCH: begin
          if (step == STEP_LAST) begin
            state <= S_OUT;
          end else begin
            t <= (t_step > 33'h7fff_ffff) ? 31'h7fff_ffff : t_step[30:0];
            step <= step + 1'b1;
            idx <= '0;
            state <= S_PT;
          end
        end
        S_DIV_GO: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            nvec[idx] <= gvec[idx][32] ? 18'(-q18) : q18;
            if (idx == 2'd2) begin
              state <= S_OUT;
            end else begin
              idx <= idx + 2'd1;
              state <= S_DIV_GO;
            end
          end
        end
        S_OUT: begin
          done_r <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  sst_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .go       (sq_go),
    .radicand (acc),
    .done     (sq_done),
    .root     (sq_root)
  );

  sst_div #(
    .NW (DIV_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .num  (div_num),
    .den  (len),
    .done (div_done),
    .quot (div_quot)
  );

  assign busy = (state != S_IDLE);
  assign done = done_r;
  assign hit = hit_r;
  assign signed_distance = sd;
  assign hit_x = pvec[0];
  assign hit_y = pvec[1];
  assign hit_z = pvec[2];
  assign normal_x = nvec[0];
  assign normal_y = nvec[1];
  assign normal_z = nvec[2];

endmodule

### hdl/sst_checker.sv
// Port-level checks on the sphere tracer and the bind that attaches them.
module sst_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic               hit,
  input logic signed [17:0] normal_x,
  input logic signed [17:0] normal_y,
  input logic signed [17:0] normal_z
);
  import sst_pkg::*;

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result word strobe lasted more than one cycle");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not make the core busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result word without a ray in flight");

  a_miss_normal: assert property (@(posedge clk) disable iff (rst)
    (done && !hit) |-> (normal_x == 18'sd0 && normal_y == 18'sd0 && normal_z == 18'sd0))
    else $error("miss reported a nonzero normal");

  a_reset_idle: assert property (@(posedge clk) rst |=> (!busy && !done))
    else $error("core not idle after reset");

endmodule

bind sdf_sphere_tracer_core sst_checker u_sst_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .done     (done),
  .hit      (hit),
  .normal_x (normal_x),
  .normal_y (normal_y),
  .normal_z (normal_z)
);
